// ===== rtl/core/wcr_pkg.sv =====
// types, constants and saturation helpers for the wall collision resolver
`default_nettype none

package wcr_pkg;

    // register word indexes on the apb port (byte address is 4 * index)
    localparam logic [1:0] RegWorldWidth = 2'd0;
    localparam logic [1:0] RegWorldHeight = 2'd1;
    localparam logic [1:0] RegAngFriction = 2'd2;

    localparam int unsigned CfgW = 31;
    localparam int unsigned ProdW = 63;
    localparam int unsigned TorqW = 48;
    localparam int unsigned SumW = 50;

    localparam logic [CfgW-1:0] WorldSizeReset = 31'd65536000;
    localparam logic [CfgW-1:0] AngFrictionReset = 31'd0;

    // wall normal sign, two's complement
    typedef enum logic [1:0] {
        SIGN_ZERO = 2'b00,
        SIGN_POS  = 2'b01,
        SIGN_NEG  = 2'b11
    } sign_t;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat50(input logic signed [SumW-1:0] v);
        logic signed [31:0] r;
        if (v[SumW-1:31] == '0 || v[SumW-1:31] == '1) begin
            r = v[31:0];
        end else if (v[SumW-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wall_collision_resolve.sv =====
// Wall collision resolver top level: vertex folding, push-out and wall friction
// A closing beat (circle or last vertex) gives its result via input, push and output registers.
// Throughput: one beat per cycle unless m_tready stalls; vertex folding loops on the push regs.
// The two 32x32 friction products are registered before rounding and the final sum.
// Stage bubbles let a new beat enter while a finished result waits on m_tready.
// Reset (aresetn low, synchronous) empties the pipe, clears the push state and loads reset config.
`default_nettype none

module wall_collision_resolve
    import wcr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, radius, speed_x, speed_y, ang_speed, vertex_x, vertex_y, zero pad
    input  wire logic [255:0] s_tdata,
    input  wire logic         s_tuser,   // has_polygon
    input  wire logic         s_tlast,   // last_vertex
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // new_pos_x, new_pos_y, new_ang_speed
    output logic              m_tuser,   // hit_wall
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration registers
    logic [CfgW-1:0] width_reg;
    logic [CfgW-1:0] height_reg;
    logic [CfgW-1:0] fric_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WorldSizeReset;
            height_reg <= WorldSizeReset;
            fric_reg   <= AngFrictionReset;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                RegWorldWidth:  width_reg  <= pwdata[CfgW-1:0];
                RegWorldHeight: height_reg <= pwdata[CfgW-1:0];
                RegAngFriction: fric_reg   <= pwdata[CfgW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            RegWorldWidth:  prdata = {1'b0, width_reg};
            RegWorldHeight: prdata = {1'b0, height_reg};
            RegAngFriction: prdata = {1'b0, fric_reg};
            default:        prdata = '0;
        endcase
    end

    // stage handshakes
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    assign en3 = !v3_reg || m_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: input register
    logic signed [31:0] x1_reg, y1_reg, sx1_reg, sy1_reg, ang1_reg, vx1_reg, vy1_reg;
    logic [30:0]        r1_reg;
    logic               poly1_reg, last1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            x1_reg    <= s_tdata[31:0];
            y1_reg    <= s_tdata[63:32];
            r1_reg    <= s_tdata[94:64];
            sx1_reg   <= s_tdata[126:95];
            sy1_reg   <= s_tdata[158:127];
            ang1_reg  <= s_tdata[190:159];
            vx1_reg   <= s_tdata[222:191];
            vy1_reg   <= s_tdata[254:223];
            poly1_reg <= s_tuser;
            last1_reg <= s_tlast;
        end
    end

    // running push state over a polygon's vertices
    logic signed [31:0] push_x_reg, push_y_reg;
    sign_t              nx_reg, ny_reg;

    // stage 1 to 2 logic
    logic signed [33:0] xe, ye, re, we, he, vxe, vye, pxe, pye;
    logic               fx_lo, fx_hi, fy_lo, fy_hi;
    logic               cx_lo, cx_hi, cy_lo, cy_hi;
    logic               clear, emit;
    logic signed [31:0] fold_px, fold_py, circ_px, circ_py, res_px, res_py;
    sign_t              fold_nx, fold_ny, circ_nx, circ_ny, res_nx, res_ny;
    logic signed [31:0] fric_s;
    logic signed [ProdW-1:0] prod_x, prod_y;

    always_comb begin
        xe  = {{2{x1_reg[31]}}, x1_reg};
        ye  = {{2{y1_reg[31]}}, y1_reg};
        vxe = {{2{vx1_reg[31]}}, vx1_reg};
        vye = {{2{vy1_reg[31]}}, vy1_reg};
        pxe = {{2{push_x_reg[31]}}, push_x_reg};
        pye = {{2{push_y_reg[31]}}, push_y_reg};
        re  = {3'b000, r1_reg};
        we  = {3'b000, width_reg};
        he  = {3'b000, height_reg};

        // deepest vertex outside each wall; low and high walls cannot both trip
        fx_lo = (vxe < 34'sd0) && (vxe < -pxe);
        fx_hi = (vxe > we) && ((vxe - we) > -pxe);
        fy_lo = (vye < 34'sd0) && (vye < -pye);
        fy_hi = (vye > he) && ((vye - he) > -pye);

        fold_px = push_x_reg;
        fold_nx = nx_reg;
        if (fx_lo) begin
            fold_px = sat34(-vxe);
            fold_nx = SIGN_POS;
        end else if (fx_hi) begin
            fold_px = sat34(we - vxe);
            fold_nx = SIGN_NEG;
        end
        fold_py = push_y_reg;
        fold_ny = ny_reg;
        if (fy_lo) begin
            fold_py = sat34(-vye);
            fold_ny = SIGN_POS;
        end else if (fy_hi) begin
            fold_py = sat34(he - vye);
            fold_ny = SIGN_NEG;
        end

        // circle against the walls, far wall wins
        cx_lo = (xe - re) < 34'sd0;
        cx_hi = (xe + re) > we;
        cy_lo = (ye - re) < 34'sd0;
        cy_hi = (ye + re) > he;

        circ_px = '0;
        circ_nx = SIGN_ZERO;
        if (cx_hi) begin
            circ_px = sat34(we - xe - re);
            circ_nx = SIGN_NEG;
        end else if (cx_lo) begin
            circ_px = sat34(re - xe);
            circ_nx = SIGN_POS;
        end
        circ_py = '0;
        circ_ny = SIGN_ZERO;
        if (cy_hi) begin
            circ_py = sat34(he - ye - re);
            circ_ny = SIGN_NEG;
        end else if (cy_lo) begin
            circ_py = sat34(re - ye);
            circ_ny = SIGN_POS;
        end

        clear = (xe > re) && (ye > re) && ((we - xe) > re) && ((he - ye) > re);
        emit  = !poly1_reg || last1_reg;

        if (clear) begin
            res_px = '0;
            res_py = '0;
            res_nx = SIGN_ZERO;
            res_ny = SIGN_ZERO;
        end else if (poly1_reg) begin
            res_px = fold_px;
            res_py = fold_py;
            res_nx = fold_nx;
            res_ny = fold_ny;
        end else begin
            res_px = circ_px;
            res_py = circ_py;
            res_nx = circ_nx;
            res_ny = circ_ny;
        end

        fric_s = {1'b0, fric_reg};
        prod_x = sx1_reg * fric_s;
        prod_y = sy1_reg * fric_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            push_x_reg <= '0;
            push_y_reg <= '0;
            nx_reg     <= SIGN_ZERO;
            ny_reg     <= SIGN_ZERO;
        end else if (v1_reg && en2) begin
            if (emit) begin
                push_x_reg <= '0;
                push_y_reg <= '0;
                nx_reg     <= SIGN_ZERO;
                ny_reg     <= SIGN_ZERO;
            end else begin
                push_x_reg <= fold_px;
                push_y_reg <= fold_py;
                nx_reg     <= fold_nx;
                ny_reg     <= fold_ny;
            end
        end
    end

    // stage 2: push result and friction products
    logic                    hit2_reg;
    logic signed [31:0]      x2_reg, y2_reg, ang2_reg, px2_reg, py2_reg;
    sign_t                   nx2_reg, ny2_reg;
    logic signed [ProdW-1:0] prodx2_reg, prody2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            hit2_reg   <= !clear;
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            ang2_reg   <= ang1_reg;
            px2_reg    <= res_px;
            py2_reg    <= res_py;
            nx2_reg    <= res_nx;
            ny2_reg    <= res_ny;
            prodx2_reg <= prod_x;
            prody2_reg <= prod_y;
        end
    end

    // stage 2 to 3: round to nearest (ties up), friction sum, saturation
    logic signed [ProdW:0]   rnd_x, rnd_y;
    logic signed [TorqW-1:0] tx, ty;
    logic signed [SumW-1:0]  ang_e, term_x, term_y, ang_sum;
    logic signed [33:0]      npx_e, npy_e;

    always_comb begin
        rnd_x = {prodx2_reg[ProdW-1], prodx2_reg} + 64'sd32768;
        rnd_y = {prody2_reg[ProdW-1], prody2_reg} + 64'sd32768;
        tx = rnd_x[ProdW:16];
        ty = rnd_y[ProdW:16];

        case (nx2_reg)
            SIGN_POS: term_x = {{(SumW-TorqW){ty[TorqW-1]}}, ty};
            SIGN_NEG: term_x = -{{(SumW-TorqW){ty[TorqW-1]}}, ty};
            default:  term_x = '0;
        endcase
        case (ny2_reg)
            SIGN_POS: term_y = -{{(SumW-TorqW){tx[TorqW-1]}}, tx};
            SIGN_NEG: term_y = {{(SumW-TorqW){tx[TorqW-1]}}, tx};
            default:  term_y = '0;
        endcase
        ang_e   = {{(SumW-32){ang2_reg[31]}}, ang2_reg};
        ang_sum = ang_e + term_x + term_y;

        npx_e = {{2{x2_reg[31]}}, x2_reg} + {{2{px2_reg[31]}}, px2_reg};
        npy_e = {{2{y2_reg[31]}}, y2_reg} + {{2{py2_reg[31]}}, py2_reg};
    end

    // stage 3: output register
    logic               hit3_reg;
    logic signed [31:0] npx3_reg, npy3_reg, na3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            hit3_reg <= hit2_reg;
            npx3_reg <= sat34(npx_e);
            npy3_reg <= sat34(npy_e);
            na3_reg  <= sat50(ang_sum);
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tuser  = hit3_reg;
    assign m_tdata  = {na3_reg, npy3_reg, npx3_reg};

`ifndef SYNTHESIS
    // push state is empty after any beat that closes an object
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && en2 && (!poly1_reg || last1_reg)) |=>
        (push_x_reg == '0 && push_y_reg == '0 && nx_reg == SIGN_ZERO && ny_reg == SIGN_ZERO))
        else $error("push state not cleared after closing beat");

    // an object clear of the walls carries no push
    a_clear_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !hit2_reg) |->
        (px2_reg == '0 && py2_reg == '0 && nx2_reg == SIGN_ZERO && ny2_reg == SIGN_ZERO))
        else $error("push present on clear object");

    // a nonzero push always comes with a wall normal
    a_push_has_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> ((px2_reg == '0 || nx2_reg != SIGN_ZERO) &&
                    (py2_reg == '0 || ny2_reg != SIGN_ZERO)))
        else $error("push without wall normal");

    // push points away from the wall it came from
    a_push_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> ((nx2_reg != SIGN_POS || (!px2_reg[31] && px2_reg != '0)) &&
                    (nx2_reg != SIGN_NEG || px2_reg[31]) &&
                    (ny2_reg != SIGN_POS || (!py2_reg[31] && py2_reg != '0)) &&
                    (ny2_reg != SIGN_NEG || py2_reg[31])))
        else $error("push sign disagrees with wall normal");
`endif

endmodule

`default_nettype wire
